/* sv/tccw_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the console cell writer.
package tccw_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int TAB_SPACES_DEF = 4;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ADDR_IN_W  = 11;
    localparam int DATA_W     = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_COLOR = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BLANK_COLOR_RST = 8'd7;
    localparam logic [CFG_DATA_W-1:0] SPACE_COLOR_RST = 8'd15;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic init_fill;
        logic clr_fill;
        logic rd_prime;
        logic sweep_write;
        logic step_char;
        logic step_space;
        logic backspace;
        logic newline;
        logic carriage;
        logic home;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_nl;
        logic            is_cr;
        logic            is_bs;
        logic            is_tab;
        logic            col_zero;
        logic            step_scroll;
        logic            nl_scroll;
        logic            idx_last;
    } t_dp_stat;

endpackage

/* sv/tccw_ctrl.sv */
// Controller state machine: sequences init fill, put, tab, clear, scroll and result strobe.
module tccw_ctrl import tccw_pkg::*; #(
    parameter int TAB_SPACES = TAB_SPACES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int TAB_W = $clog2(TAB_SPACES + 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_TAB,
        ST_CLEAR,
        ST_PRIME,
        ST_SCROLL
    } t_state;

    t_state           r_state, n_state;
    logic [TAB_W-1:0] r_tab_left, n_tab_left;
    logic             r_busy;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_tab_left = r_tab_left;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_fill = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_tab_left = '0;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_stat.op)
                    OP_PUT: begin
                        if (i_stat.is_nl) begin
                            o_cmd.newline = 1'b1;
                            if (i_stat.nl_scroll) begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = ST_PRIME;
                            end else begin
                                o_cmd.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end else if (i_stat.is_cr) begin
                            o_cmd.carriage = 1'b1;
                            o_cmd.finish   = 1'b1;
                            n_state        = ST_IDLE;
                        end else if (i_stat.is_bs) begin
                            o_cmd.backspace = !i_stat.col_zero;
                            o_cmd.finish    = 1'b1;
                            n_state         = ST_IDLE;
                        end else if (i_stat.is_tab) begin
                            n_tab_left = TAB_W'(TAB_SPACES);
                            n_state    = ST_TAB;
                        end else begin
                            o_cmd.step_char = 1'b1;
                            if (i_stat.step_scroll) begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = ST_PRIME;
                            end else begin
                                o_cmd.finish = 1'b1;
                                n_state      = ST_IDLE;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_state = ST_CLEAR;
                    end
                    OP_READ: begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                endcase
            end
            ST_TAB: begin
                o_cmd.step_space = 1'b1;
                n_tab_left       = r_tab_left - TAB_W'(1);
                if (i_stat.step_scroll) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_PRIME;
                end else if (r_tab_left == TAB_W'(1)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_fill = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.home   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_PRIME: begin
                o_cmd.rd_prime = 1'b1;
                n_state        = ST_SCROLL;
            end
            ST_SCROLL: begin
                o_cmd.sweep_write = 1'b1;
                if (i_stat.idx_last) begin
                    // resume a tab that wrapped into the scroll
                    if (r_tab_left != '0) begin
                        n_state = ST_TAB;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_tab_left <= '0;
            r_busy     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_tab_left <= n_tab_left;
            r_busy     <= (n_state != ST_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

/* sv/tccw_datapath.sv */
// Datapath: screen memory, cursor, colour registers, sweep counter and result registers.
module tccw_datapath import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [CHAR_W-1:0]     i_char_color,
    input  logic [ADDR_IN_W-1:0]  i_cell_address,
    output logic                  o_done,
    output logic [DATA_W-1:0]     o_read_data,
    output logic [ROW_OUT_W-1:0]  o_cursor_row,
    output logic [COL_OUT_W-1:0]  o_cursor_column,
    output logic [POS_OUT_W-1:0]  o_cursor_position,
    output logic                  o_scrolled
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int SCR_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int RA_W      = $clog2(CELLS + COLUMNS + 1);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam logic [DATA_W-1:0] RESET_CELL = {BLANK_COLOR_RST, CH_SPACE};

    logic [DATA_W-1:0]     r_mem [CELLS];
    logic [DATA_W-1:0]     r_rd_data;
    logic [OP_W-1:0]       r_op;
    logic [CHAR_W-1:0]     r_code;
    logic [CHAR_W-1:0]     r_color;
    logic                  r_rd_ok;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_scrolled, n_scrolled;
    logic [CFG_DATA_W-1:0] r_blank_color;
    logic [CFG_DATA_W-1:0] r_space_color;
    logic                  r_done;
    logic [DATA_W-1:0]     r_read_data;
    logic [ROW_OUT_W-1:0]  r_cursor_row;
    logic [COL_OUT_W-1:0]  r_cursor_column;
    logic [POS_OUT_W-1:0]  r_cursor_position;
    logic                  r_out_scrolled;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] n_pos;
    logic              col_last;
    logic              row_last;
    logic              scroll_now;
    logic [DATA_W-1:0] blank_cell;
    logic [DATA_W-1:0] space_cell;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [RA_W-1:0]   sweep_rd_addr;
    logic              in_ok;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign cur_addr   = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign col_last   = (r_col == COL_W'(COLUMNS - 1));
    assign row_last   = (r_row == ROW_W'(ROWS - 1));
    assign blank_cell = {r_blank_color, CH_SPACE};
    assign space_cell = {r_space_color, CH_SPACE};
    assign in_ok      = (int'(i_cell_address) < CELLS);

    // Cursor update; a move past the last row keeps the row and flags a scroll
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        scroll_now = 1'b0;
        if (i_cmd.home) begin
            n_row = '0;
            n_col = '0;
        end else if (i_cmd.step_char || i_cmd.step_space) begin
            if (col_last) begin
                n_col = '0;
                if (row_last) begin
                    scroll_now = 1'b1;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (i_cmd.newline) begin
            n_col = '0;
            if (row_last) begin
                scroll_now = 1'b1;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end else if (i_cmd.carriage) begin
            n_col = '0;
        end else if (i_cmd.backspace) begin
            n_col = r_col - COL_W'(1);
        end
    end

    assign n_scrolled = i_cmd.load ? 1'b0 : (r_scrolled | scroll_now);
    assign n_pos      = ADDR_W'(n_row) * ADDR_W'(COLUMNS) + ADDR_W'(n_col);

    // Single write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = blank_cell;
        if (i_cmd.init_fill) begin
            wr_en   = 1'b1;
            wr_data = RESET_CELL;
        end else if (i_cmd.clr_fill) begin
            wr_en = 1'b1;
        end else if (i_cmd.sweep_write) begin
            wr_en   = 1'b1;
            wr_data = (r_idx < ADDR_W'(SCR_CELLS)) ? r_rd_data : blank_cell;
        end else if (i_cmd.step_char) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {r_color, r_code};
        end else if (i_cmd.step_space) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = space_cell;
        end else if (i_cmd.backspace) begin
            wr_en   = 1'b1;
            wr_addr = cur_addr - ADDR_W'(1);
            wr_data = space_cell;
        end
    end

    // Read port: the requested cell at transfer, one row ahead during a scroll
    assign sweep_rd_addr = RA_W'(r_idx) + RA_W'(COLUMNS) + RA_W'(i_cmd.sweep_write);

    always_comb begin
        if (i_cmd.load) begin
            rd_en   = in_ok;
            rd_addr = ADDR_W'(i_cell_address);
        end else begin
            rd_en   = (i_cmd.rd_prime || i_cmd.sweep_write) && (sweep_rd_addr < RA_W'(CELLS));
            rd_addr = ADDR_W'(sweep_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_col         <= '0;
            r_idx         <= '0;
            r_scrolled    <= 1'b0;
            r_blank_color <= BLANK_COLOR_RST;
            r_space_color <= SPACE_COLOR_RST;
            r_done        <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_scrolled <= n_scrolled;
            r_done     <= i_cmd.finish;
            if (i_cmd.load || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.init_fill || i_cmd.clr_fill || i_cmd.sweep_write) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLANK_COLOR: r_blank_color <= i_cfg_data;
                    CFG_SPACE_COLOR: r_space_color <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Captured item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_code  <= i_char_code;
            r_color <= i_char_color;
            r_rd_ok <= in_ok;
        end
        if (i_cmd.finish) begin
            r_read_data       <= (r_op == OP_READ && r_rd_ok) ? r_rd_data : '0;
            r_cursor_row      <= ROW_OUT_W'(n_row);
            r_cursor_column   <= COL_OUT_W'(n_col);
            r_cursor_position <= POS_OUT_W'(n_pos);
            r_out_scrolled    <= n_scrolled;
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.is_nl       = (r_code == CH_NL);
    assign o_stat.is_cr       = (r_code == CH_CR);
    assign o_stat.is_bs       = (r_code == CH_BS);
    assign o_stat.is_tab      = (r_code == CH_TAB);
    assign o_stat.col_zero    = (r_col == '0);
    assign o_stat.step_scroll = col_last && row_last;
    assign o_stat.nl_scroll   = row_last;
    assign o_stat.idx_last    = (r_idx == ADDR_W'(CELLS - 1));

    assign o_done            = r_done;
    assign o_read_data       = r_read_data;
    assign o_cursor_row      = r_cursor_row;
    assign o_cursor_column   = r_cursor_column;
    assign o_cursor_position = r_cursor_position;
    assign o_scrolled        = r_out_scrolled;

endmodule

/* sv/text_console_cell_writer_core.sv */
// Top level of the text console cell writer: controller, datapath and checks.
//
// A command is taken when start is high and busy is low; its result shows on the o_ ports for
// one cycle with o_done high, and cannot be held off. All screen traffic goes through one cell
// memory with one write port and one read port, and the write port sets the pace: put, return,
// newline, backspace, read and the unused opcode finish from the execute state; a tab writes
// TAB_SPACES spaces. A step that scrolls adds a sweep of the whole screen (one read-ahead, then
// one cell per cycle), and clear blanks the whole screen cell by cell. After reset, busy stays
// high while the screen is filled with blanks; colour writes are taken then.
module text_console_cell_writer_core import tccw_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int TAB_SPACES = TAB_SPACES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [CHAR_W-1:0]     i_char_color,
    input  logic [ADDR_IN_W-1:0]  i_cell_address,
    output logic                  o_done,
    output logic [DATA_W-1:0]     o_read_data,
    output logic [ROW_OUT_W-1:0]  o_cursor_row,
    output logic [COL_OUT_W-1:0]  o_cursor_column,
    output logic [POS_OUT_W-1:0]  o_cursor_position,
    output logic                  o_scrolled
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tccw_ctrl #(
        .TAB_SPACES(TAB_SPACES)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    tccw_datapath #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_char_code      (i_char_code),
        .i_char_color     (i_char_color),
        .i_cell_address   (i_cell_address),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column),
        .o_cursor_position(o_cursor_position),
        .o_scrolled       (o_scrolled)
    );

    // A transfer always makes the block busy in the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer");

    // The result strobe only shows once the block is free again
    a_done_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // At most one source drives the memory write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.init_fill, cmd.clr_fill, cmd.sweep_write,
                  cmd.step_char, cmd.step_space, cmd.backspace}))
        else $error("memory write port contention");

    // A scroll always leaves the cursor on the last row
    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_scrolled |-> o_cursor_row == ROW_OUT_W'(ROWS - 1))
        else $error("cursor not on last row after scroll");

    // Column never reaches the row width in a result
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> int'(o_cursor_column) < COLUMNS)
        else $error("cursor column out of range");

endmodule

/* sim/text_console_cell_writer_core_test.sv */
// Self-checking testbench for the text console cell writer: directed table, then random text.
module text_console_cell_writer_core_test;
    import tccw_pkg::*;

    localparam int NCOL   = COLUMNS_DEF;
    localparam int NROW   = ROWS_DEF;
    localparam int NTAB   = TAB_SPACES_DEF;
    localparam int NCELLS = NCOL * NROW;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CHAR_W-1:0]    ch;
        logic [CHAR_W-1:0]    colour;
        logic [ADDR_IN_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [POS_OUT_W-1:0] pos;
        logic                 scrolled;
    } t_cell_result;

    typedef struct packed {
        t_cmd         cmd;
        logic [7:0]   reps;
        logic         typed;
        t_cell_result want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_BLANK_COLOR;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic [OP_W-1:0]       i_op = OP_PUT;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [CHAR_W-1:0]     i_char_color = '0;
    logic [ADDR_IN_W-1:0]  i_cell_address = '0;
    logic                  o_done;
    logic [DATA_W-1:0]     o_read_data;
    logic [ROW_OUT_W-1:0]  o_cursor_row;
    logic [COL_OUT_W-1:0]  o_cursor_column;
    logic [POS_OUT_W-1:0]  o_cursor_position;
    logic                  o_scrolled;

    text_console_cell_writer_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_char_code       (i_char_code),
        .i_char_color      (i_char_color),
        .i_cell_address    (i_cell_address),
        .o_done            (o_done),
        .o_read_data       (o_read_data),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_position (o_cursor_position),
        .o_scrolled        (o_scrolled)
    );

    always #1 i_clk = ~i_clk;

    // Screen and cursor as the block should hold them
    logic [DATA_W-1:0] screen_model [0:NCELLS-1];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [7:0]        blank_colour = BLANK_COLOR_RST;
    logic [7:0]        space_colour = SPACE_COLOR_RST;
    bit                step_scrolled;

    t_cell_result pending_results[$];
    t_cell_result oldest_result;
    t_stim_row    directed_rows[$];
    bit           idling_on = 1'b1;
    int           mismatches = 0;
    int           results_checked = 0;
    int           scrolls_seen = 0;
    int           cmds_sent = 0;
    int           reads_sent = 0;
    int           clears_sent = 0;
    int           settings_used = 1;

    initial begin
        for (int i = 0; i < NCELLS; i++) screen_model[i] = {BLANK_COLOR_RST, CH_SPACE};
        cur_row = 0;
        cur_col = 0;
    end

    function automatic void blank_screen();
        for (int i = 0; i < NCELLS; i++) screen_model[i] = {blank_colour, CH_SPACE};
    endfunction

    function automatic void scroll_if_needed();
        if (cur_row >= NROW) begin
            for (int i = 0; i < (NROW - 1) * NCOL; i++) screen_model[i] = screen_model[i + NCOL];
            for (int i = (NROW - 1) * NCOL; i < NCELLS; i++)
                screen_model[i] = {blank_colour, CH_SPACE};
            cur_row = NROW - 1;
            step_scrolled = 1'b1;
        end
    endfunction

    function automatic void write_cell(logic [7:0] ch, logic [7:0] colour);
        screen_model[cur_row * NCOL + cur_col] = {colour, ch};
        cur_col++;
        if (cur_col >= NCOL) begin
            cur_col = 0;
            cur_row++;
        end
        scroll_if_needed();
    endfunction

    function automatic void put_char(logic [7:0] ch, logic [7:0] colour);
        if (ch == CH_NL) begin
            cur_row++;
            cur_col = 0;
            scroll_if_needed();
        end else if (ch == CH_BS) begin
            if (cur_col != 0) begin
                cur_col--;
                write_cell(CH_SPACE, space_colour);
                cur_col = (cur_col == 0) ? 0 : cur_col - 1;
            end
        end else if (ch == CH_TAB) begin
            repeat (NTAB) write_cell(CH_SPACE, space_colour);
        end else if (ch == CH_CR) begin
            cur_col = 0;
        end else begin
            write_cell(ch, colour);
        end
    endfunction

    // Apply one command to the screen and cursor, return the result it should give
    function automatic t_cell_result console_step(t_cmd c);
        t_cell_result r;
        int unsigned  pos;
        r = '0;
        step_scrolled = 1'b0;
        case (c.op)
            OP_PUT: put_char(c.ch, c.colour);
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            OP_READ: if (c.addr < NCELLS) r.data = screen_model[c.addr];
            default: ;
        endcase
        pos = cur_row * NCOL + cur_col;
        r.row = cur_row[ROW_OUT_W-1:0];
        r.col = cur_col[COL_OUT_W-1:0];
        r.pos = pos[POS_OUT_W-1:0];
        r.scrolled = step_scrolled;
        return r;
    endfunction

    function automatic t_stim_row stim(logic [OP_W-1:0] op, logic [7:0] ch, logic [7:0] colour,
                                       int addr, int reps, bit typed, int data, int row, int col,
                                       bit scr);
        t_stim_row s;
        int        pos;
        pos = row * NCOL + col;
        s.cmd = '{op, ch, colour, addr[ADDR_IN_W-1:0]};
        s.reps = reps[7:0];
        s.typed = typed;
        s.want = '{data[DATA_W-1:0], row[ROW_OUT_W-1:0], col[COL_OUT_W-1:0],
                   pos[POS_OUT_W-1:0], scr};
        return s;
    endfunction

    // Mostly ordinary text with control codes mixed in; reads favour the cell just written
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        int   near;
        pick = $urandom_range(0, 99);
        c.op = OP_PUT;
        c.ch = 8'($urandom_range(8'h21, 8'h7E));
        c.colour = 8'($urandom);
        c.addr = 11'($urandom_range(0, NCELLS - 1));
        if (pick < 55) begin
        end else if (pick < 62) begin
            c.ch = 8'($urandom);
        end else if (pick < 70) begin
            c.ch = CH_NL;
        end else if (pick < 73) begin
            c.ch = CH_CR;
        end else if (pick < 78) begin
            c.ch = CH_BS;
        end else if (pick < 82) begin
            c.ch = CH_TAB;
        end else if (pick < 96) begin
            c.op = OP_READ;
            c.ch = 8'($urandom);
            pick = $urandom_range(0, 9);
            near = cur_row * NCOL + cur_col + NCELLS - 1 - $urandom_range(0, 3);
            if (pick < 6) c.addr = 11'(near % NCELLS);
            else if (pick == 9) c.addr = 11'($urandom_range(NCELLS, 2 ** ADDR_IN_W - 1));
        end else if (pick < 98) begin
            c.op = OP_CLEAR;
        end else begin
            c.op = OP_UNUSED;
            c.addr = 11'($urandom);
        end
        return c;
    endfunction

    function automatic int idle_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (!idling_on || p < 40) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Hold the command until the block takes it, then record what it should give back
    task automatic issue_cmd(t_cmd c, bit use_typed, t_cell_result typed_result, int gap);
        t_cell_result predicted;
        start <= 1'b1;
        i_op <= c.op;
        i_char_code <= c.ch;
        i_char_color <= c.colour;
        i_cell_address <= c.addr;
        do @(posedge i_clk); while (busy);
        predicted = console_step(c);
        pending_results.push_back(use_typed ? typed_result : predicted);
        cmds_sent++;
        if (c.op == OP_READ) reads_sent++;
        if (c.op == OP_CLEAR) clears_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_colours(logic [7:0] blank, logic [7:0] space);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_BLANK_COLOR;
        i_cfg_data <= blank;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPACE_COLOR;
        i_cfg_data <= space;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blank_colour = blank;
        space_colour = space;
        settings_used++;
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing outstanding, read_data 0x%0h", $time,
                         o_read_data);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("read_data", oldest_result.data, o_read_data);
                check_field("cursor_row", oldest_result.row, o_cursor_row);
                check_field("cursor_column", oldest_result.col, o_cursor_column);
                check_field("cursor_position", oldest_result.pos, o_cursor_position);
                check_field("scrolled", oldest_result.scrolled, o_scrolled);
                results_checked++;
                if (o_scrolled) scrolls_seen++;
            end
        end
    end

    initial begin
        t_cmd clear_cmd;
        clear_cmd = '{OP_CLEAR, 8'h00, 8'h00, 11'd0};

        // op, char, colour, address, repeats, typed, then read_data, row, column, scrolled
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 0, 1, 1, 'h0720, 0, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1999, 1, 1, 'h0720, 0, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 2000, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'hFF, 8'hFF, 2047, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_UNUSED, 8'hFF, 8'hFF, 2047, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_PUT, 8'h41, 8'h1E, 0, 1, 1, 0, 0, 1, 0));
        directed_rows.push_back(stim(OP_PUT, 8'h00, 8'h00, 0, 1, 1, 0, 0, 2, 0));
        directed_rows.push_back(stim(OP_PUT, 8'hFF, 8'hFF, 2047, 1, 1, 0, 0, 3, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 0, 1, 1, 'h1E41, 0, 3, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 2, 1, 1, 'hFFFF, 0, 3, 0));
        directed_rows.push_back(stim(OP_PUT, CH_BS, 8'h00, 0, 1, 1, 0, 0, 2, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 2, 1, 1, 'h0F20, 0, 2, 0));
        directed_rows.push_back(stim(OP_PUT, CH_CR, 8'h00, 0, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_PUT, CH_BS, 8'h00, 0, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_PUT, CH_TAB, 8'h00, 0, 1, 1, 0, 0, 4, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 3, 1, 1, 'h0F20, 0, 4, 0));
        directed_rows.push_back(stim(OP_PUT, CH_NL, 8'h00, 0, 1, 1, 0, 1, 0, 0));
        directed_rows.push_back(stim(OP_PUT, CH_NL, 8'h00, 0, 22, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_PUT, 8'h79, 8'h3C, 0, 78, 0, 0, 0, 0, 0));
        // tab across the row end wraps without scrolling, the newline after it scrolls
        directed_rows.push_back(stim(OP_PUT, CH_TAB, 8'h00, 0, 1, 1, 0, 24, 2, 0));
        directed_rows.push_back(stim(OP_PUT, CH_NL, 8'h00, 0, 1, 1, 0, 24, 0, 1));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1760, 1, 1, 'h3C79, 24, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1840, 1, 1, 'h0F20, 24, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1920, 1, 1, 'h0720, 24, 0, 0));
        directed_rows.push_back(stim(OP_PUT, 8'h7A, 8'h42, 0, 79, 0, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_PUT, 8'h7A, 8'h42, 0, 1, 1, 0, 24, 0, 1));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1919, 1, 1, 'h427A, 24, 0, 0));
        directed_rows.push_back(stim(OP_CLEAR, 8'h00, 8'h00, 0, 1, 1, 0, 0, 0, 0));
        directed_rows.push_back(stim(OP_READ, 8'h00, 8'h00, 1999, 1, 1, 'h0720, 0, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            repeat (directed_rows[i].reps)
                issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want,
                          idle_cycles());

        // Change colours only once the block has gone quiet; one phase runs without gaps
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                0: set_colours(8'h00, 8'hFF);
                1: set_colours(8'hFF, 8'h00);
                default: set_colours(8'($urandom), 8'($urandom));
            endcase
            idling_on = (phase != 2);
            issue_cmd(clear_cmd, 1'b0, '0, idle_cycles());
            repeat (140) issue_cmd(random_cmd(), 1'b0, '0, idle_cycles());
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d commands under %0d colour settings: %0d reads, %0d clears.",
                 cmds_sent, settings_used, reads_sent, clears_sent);
        $display("Checked %0d results, %0d of them scrolled; %0d mismatches.",
                 results_checked, scrolls_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Worst case is every command scrolling or clearing after a long gap, taken several times
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
sv/tccw_pkg.sv
sv/tccw_ctrl.sv
sv/tccw_datapath.sv
sv/text_console_cell_writer_core.sv
sim/text_console_cell_writer_core_test.sv
